### hw/rtl/biip_pkg.sv
package biip_pkg;

   typedef logic signed [15:0] sample_type;
   typedef logic [5:0] delay_type;
   typedef logic [1:0] csr_index_type;
   typedef logic [15:0] csr_data_type;
   typedef logic signed [33:0] product_type;

   localparam csr_index_type REG_SIN_AZIMUTH = 2'd0;
   localparam csr_index_type REG_AZIMUTH_POSITIVE = 2'd1;
   localparam csr_index_type REG_DELAY_SAMPLES = 2'd2;

   localparam logic signed [17:0] GAIN_UNITY = 18'sd32768;
   localparam logic signed [17:0] LP_ALPHA = 18'sd13107;
   localparam logic signed [17:0] LP_KEEP = 18'sd52429;

   typedef struct packed {
      logic mul_en;
      logic lp_en;
      logic fin_en;
   } step_type;

   // Divides by 65536 rounding to nearest, ties upward, then clamps to 16 bits.
   function automatic sample_type round_sat(input product_type p);
      logic signed [34:0] biased;
      logic signed [18:0] q;
      sample_type r;
      biased = {p[33], p} + 35'sd32768;
      q = biased[34:16];
      if (q > 19'sd32767) begin
         r = 16'sh7FFF;
      end else if (q < -19'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = q[15:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/biip_sample_if.sv
interface biip_sample_if;
   logic valid;
   logic ready;
   biip_pkg::sample_type mono_sample;

   modport source(output valid, output mono_sample, input ready);
   modport sink(input valid, input mono_sample, output ready);
endinterface

### hw/rtl/biip_stereo_if.sv
interface biip_stereo_if;
   logic valid;
   logic ready;
   biip_pkg::sample_type left_sample;
   biip_pkg::sample_type right_sample;

   modport source(output valid, output left_sample, output right_sample, input ready);
   modport sink(input valid, input left_sample, input right_sample, output ready);
endinterface

### hw/rtl/biip_csr_if.sv
interface biip_csr_if;
   logic valid;
   logic ready;
   biip_pkg::csr_index_type index;
   biip_pkg::csr_data_type data;

   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

### hw/rtl/binaural_itd_ild_panner_top.sv
// Binaural panner: one mono Q1.15 sample in, one saturated stereo pair out.
// The req_ch channel carries mono_sample beats, the rsp_ch channel carries
// left_sample and right_sample beats, and csr_ch writes sin_azimuth (index 0),
// azimuth_positive (index 1) and delay_samples (index 2); other indexes are
// dropped. Configuration must be written only while no sample is in flight;
// the block itself does not enforce it. An accepted sample is written into
// the delay memory in the same cycle that the far-ear tap is read, so a zero
// delay forwards the current sample. After acceptance the sample passes S_MUL
// for the gain multipliers, S_RND for rounding and the filter multiply-add,
// and S_FIN to round the filter and load the output register. One sample is
// in flight at a time: the next is taken only after S_FIN has finished.
// A finished result waits in the output register while the next sample is
// accepted; if the receiver stalls and the next result is done, the block
// holds it in its final step until the output register frees up.
// Reset clears the delay memory valid bits, the write pointer, both filter
// states and the configuration registers.
module binaural_itd_ild_panner_top #(
   parameter int DELAY_DEPTH = 64
) (
   input logic           clock,
   input logic           reset,
   biip_sample_if.sink   req_ch,
   biip_stereo_if.source rsp_ch,
   biip_csr_if.sink      csr_ch
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL = 2'd1;
   localparam logic [1:0] S_RND = 2'd2;
   localparam logic [1:0] S_FIN = 2'd3;

   logic [1:0] state_ff, state_in;
   logic accept;
   logic out_free;
   biip_pkg::step_type step;

   biip_pkg::sample_type sin_azimuth_ff;
   logic azimuth_positive_ff;
   biip_pkg::delay_type delay_samples_ff;

   biip_pkg::sample_type near_sample, far_sample;
   biip_pkg::sample_type mix_left, mix_right;
   biip_pkg::sample_type left_ff, right_ff;
   logic rsp_valid_ff;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      step = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            step.mul_en = 1'b1;
            state_in = S_RND;
         end
         S_RND: begin
            step.lp_en = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               step.fin_en = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sin_azimuth_ff <= '0;
         azimuth_positive_ff <= 1'b0;
         delay_samples_ff <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            biip_pkg::REG_SIN_AZIMUTH: begin
               sin_azimuth_ff <= csr_ch.data;
            end
            biip_pkg::REG_AZIMUTH_POSITIVE: begin
               azimuth_positive_ff <= csr_ch.data[0];
            end
            biip_pkg::REG_DELAY_SAMPLES: begin
               delay_samples_ff <= csr_ch.data[5:0];
            end
            default: begin
            end
         endcase
      end
   end

   biip_delay_line #(
      .DELAY_DEPTH(DELAY_DEPTH)
   ) u_delay_line (
      .clock(clock),
      .reset(reset),
      .wr_en(accept),
      .wr_sample(req_ch.mono_sample),
      .delay(delay_samples_ff),
      .near_sample(near_sample),
      .far_sample(far_sample)
   );

   biip_mix u_mix (
      .clock(clock),
      .reset(reset),
      .step(step),
      .near_sample(near_sample),
      .far_sample(far_sample),
      .sin_azimuth(sin_azimuth_ff),
      .azimuth_positive(azimuth_positive_ff),
      .left_sample(mix_left),
      .right_sample(mix_right)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step.fin_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step.fin_en) begin
         left_ff <= mix_left;
         right_ff <= mix_right;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.left_sample = left_ff;
   assign rsp_ch.right_sample = right_ff;

endmodule

### hw/rtl/biip_delay_line.sv
module biip_delay_line #(
   parameter int DELAY_DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  biip_pkg::sample_type wr_sample,
   input  biip_pkg::delay_type  delay,
   output biip_pkg::sample_type near_sample,
   output biip_pkg::sample_type far_sample
);

   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int IW = ((AW > 6) ? AW : 6) + 1;
   localparam logic [IW-1:0] DEPTH_I = IW'(DELAY_DEPTH);
   localparam logic [IW-1:0] LAST_I = IW'(DELAY_DEPTH - 1);

   biip_pkg::sample_type mem [DELAY_DEPTH];
   biip_pkg::sample_type rd_data_ff;
   biip_pkg::sample_type near_ff;

   logic [AW-1:0] wptr_ff, wptr_in, rd_addr;
   logic [IW-1:0] dly_i, dly_eff, wptr_i, rd_i;
   logic [DELAY_DEPTH-1:0] valid_ff, valid_in;
   logic rd_valid_ff;
   logic fwd_ff;

   always_comb begin
      dly_i = IW'(delay);
      dly_eff = (dly_i > LAST_I) ? LAST_I : dly_i;
      wptr_i = IW'(wptr_ff);
      rd_i = (wptr_i < dly_eff) ? (wptr_i + DEPTH_I - dly_eff) : (wptr_i - dly_eff);
      rd_addr = rd_i[AW-1:0];
      wptr_in = (wptr_i == LAST_I) ? '0 : (wptr_ff + AW'(1));
      valid_in = valid_ff;
      valid_in[wptr_ff] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
         fwd_ff <= 1'b0;
      end else if (wr_en) begin
         wptr_ff <= wptr_in;
         valid_ff <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
         fwd_ff <= (dly_eff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wptr_ff] <= wr_sample;
         rd_data_ff <= mem[rd_addr];
         near_ff <= wr_sample;
      end
   end

   assign near_sample = near_ff;
   assign far_sample = fwd_ff ? near_ff : (rd_valid_ff ? rd_data_ff : '0);

endmodule

### hw/rtl/biip_mix.sv
module biip_mix (
   input  logic                 clock,
   input  logic                 reset,
   input  biip_pkg::step_type   step,
   input  biip_pkg::sample_type near_sample,
   input  biip_pkg::sample_type far_sample,
   input  biip_pkg::sample_type sin_azimuth,
   input  logic                 azimuth_positive,
   output biip_pkg::sample_type left_sample,
   output biip_pkg::sample_type right_sample
);

   logic far_left;
   biip_pkg::sample_type left_src, right_src;
   logic signed [17:0] gain_l, gain_r;
   biip_pkg::product_type prod_l_ff, prod_l_in, prod_r_ff, prod_r_in;
   biip_pkg::sample_type ear_l_ff, ear_l_in, ear_r_ff, ear_r_in;
   biip_pkg::sample_type lp_u, lp_y, lp_new;
   biip_pkg::product_type lp_sum_ff, lp_sum_in;
   biip_pkg::sample_type lp_left_ff, lp_right_ff;

   always_comb begin
      far_left = (sin_azimuth > 16'sd0);
      left_src = far_left ? far_sample : near_sample;
      right_src = far_left ? near_sample : far_sample;
      gain_l = biip_pkg::GAIN_UNITY - 18'(sin_azimuth);
      gain_r = biip_pkg::GAIN_UNITY + 18'(sin_azimuth);
      prod_l_in = left_src * gain_l;
      prod_r_in = right_src * gain_r;

      ear_l_in = biip_pkg::round_sat(prod_l_ff);
      ear_r_in = biip_pkg::round_sat(prod_r_ff);
      lp_u = azimuth_positive ? ear_l_in : ear_r_in;
      lp_y = azimuth_positive ? lp_left_ff : lp_right_ff;
      lp_sum_in = lp_u * biip_pkg::LP_ALPHA + lp_y * biip_pkg::LP_KEEP;

      lp_new = biip_pkg::round_sat(lp_sum_ff);
      left_sample = azimuth_positive ? lp_new : ear_l_ff;
      right_sample = azimuth_positive ? ear_r_ff : lp_new;
   end

   always_ff @(posedge clock) begin
      if (step.mul_en) begin
         prod_l_ff <= prod_l_in;
         prod_r_ff <= prod_r_in;
      end
      if (step.lp_en) begin
         ear_l_ff <= ear_l_in;
         ear_r_ff <= ear_r_in;
         lp_sum_ff <= lp_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_left_ff <= '0;
         lp_right_ff <= '0;
      end else if (step.fin_en) begin
         if (azimuth_positive) begin
            lp_left_ff <= lp_new;
         end else begin
            lp_right_ff <= lp_new;
         end
      end
   end

endmodule
